@@ design/refcounted_slot_allocator_macros.svh @@
// Assertion macros for the refcounted slot allocator.
`ifndef REFCOUNTED_SLOT_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define RSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot allocator check failed");
`define RSA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot allocator check failed");
`else
`define RSA_ASSERT_IMP(label, clk, rst, ante, cons)
`define RSA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/rsa_pkg.sv @@
// Shared constants, codes and types of the refcounted slot allocator.
`default_nettype none
package rsa_pkg;

   localparam int SLOTS        = 1024;
   localparam int FREE_DEPTH   = 1024;  // power of two: queue pointers wrap
   localparam int COUNT_BITS   = 16;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int FQ_W         = $clog2(FREE_DEPTH);
   localparam int FQ_CNT_W     = FQ_W + 1;
   localparam int LIVE_W       = SLOT_W + 1;
   localparam int INDEX_W      = 16;
   localparam int MODE_W       = 3;
   localparam int STATUS_W     = 3;
   localparam int VACUUM_LEVEL = (FREE_DEPTH * 3) / 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE     = 3'd0,
      MODE_GRAB       = 3'd1,
      MODE_DROP       = 3'd2,
      MODE_QUERY      = 3'd3,
      MODE_SCAN_BELOW = 3'd4,
      MODE_SCAN_TOP   = 3'd5
   } rsa_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_RANGE    = 3'd1,
      STAT_NO_ENTRY = 3'd2,
      STAT_OVERFLOW = 3'd3,
      STAT_FULL     = 3'd4,
      STAT_CORRUPT  = 3'd5,
      STAT_NONE     = 3'd6
   } rsa_status_type;

   typedef struct packed {
      logic                  is_zero;
      logic                  is_max;
      logic                  sum_zero;
      logic [COUNT_BITS-1:0] sum;
   } rsa_alu_out_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      rsa_status_type    status;
      logic              flag;
      logic              vacuum;
      logic [LIVE_W-1:0] live;
   } rsa_rsp_type;

endpackage
`default_nettype wire

@@ design/rsa_ram.sv @@
// Single write port, single registered read port RAM.
`default_nettype none
module rsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ design/rsa_count_alu.sv @@
// Shared count unit: zero and saturation tests and a +1/-1 adder.
`default_nettype none
module rsa_count_alu
   import rsa_pkg::*;
(
   input  wire logic [COUNT_BITS-1:0] count,
   input  wire logic                  dec,
   output rsa_alu_out_type            result
);

   logic [COUNT_BITS-1:0] addend;

   always_comb begin
      addend          = dec ? {COUNT_BITS{1'b1}} : COUNT_BITS'(1);
      result.sum      = count + addend;
      result.is_zero  = (count == '0);
      result.is_max   = &count;
      result.sum_zero = (result.sum == '0);
   end

endmodule
`default_nettype wire

@@ design/refcounted_slot_allocator.sv @@
// Grab, drop, query and fresh create end in ST_RMW; free-queue create goes via ST_FQ;
// out of range, full and unknown mode end in ST_IDLE; scans walk one entry per cycle.
// One word in flight: the next word is taken once this one's result reaches rsp_ff.
// Every count access uses the one count RAM; count reads all feed the shared count unit.
// Synchronous reset starts a clearing pass that zeroes all SLOTS (1024) count entries,
// during which no word is taken.
`default_nettype none
`include "refcounted_slot_allocator_macros.svh"
module refcounted_slot_allocator
   import rsa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [INDEX_W-1:0]  req_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_flag,
   output logic                     rsp_vacuum_request,
   output logic [LIVE_W-1:0]        rsp_live_count
);

   localparam int SUM_W = LIVE_W + 2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FQ,
      ST_RMW,
      ST_SCAN,
      ST_HOLD
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   rsa_mode_type      mode_ff, mode_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [FQ_W-1:0]   free_head_ff, free_head_in;
   logic [FQ_CNT_W-1:0] free_count_ff, free_count_in;
   logic [LIVE_W-1:0] next_fresh_ff, next_fresh_in;
   logic [LIVE_W-1:0] live_ff, live_in;
   rsa_rsp_type       rsp_ff, rsp_in;
   rsa_rsp_type       hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              cnt_rd_en, cnt_wr_en;
   logic [SLOT_W-1:0] cnt_rd_addr, cnt_wr_addr;
   logic [COUNT_BITS-1:0] cnt_rd_data, cnt_wr_data;
   logic              fq_rd_en, fq_wr_en;
   logic [FQ_W-1:0]   fq_wr_addr;
   logic [SLOT_W-1:0] fq_rd_data;
   rsa_alu_out_type   alu;

   logic              out_free, finish, in_range;
   logic [LIVE_W-1:0] scan_start;
   rsa_rsp_type       res;

   rsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_count_ram (
      .clock   (clock),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data)
   );

   rsa_ram #(.WIDTH(SLOT_W), .DEPTH(FREE_DEPTH)) u_free_ram (
      .clock   (clock),
      .rd_en   (fq_rd_en),
      .rd_addr (free_head_ff),
      .rd_data (fq_rd_data),
      .wr_en   (fq_wr_en),
      .wr_addr (fq_wr_addr),
      .wr_data (idx_ff)
   );

   rsa_count_alu u_alu (
      .count  (cnt_rd_data),
      .dec    (mode_ff == MODE_DROP),
      .result (alu)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign in_range   = {1'b0, req_index} < (INDEX_W+1)'(SLOTS);
   assign fq_wr_addr = free_head_ff + free_count_ff[FQ_W-1:0];

   always_comb begin
      if (rsa_mode_type'(req_mode) == MODE_SCAN_TOP) begin
         scan_start = next_fresh_ff;
      end else if ({1'b0, req_index} > (INDEX_W+1)'(SLOTS)) begin
         scan_start = LIVE_W'(SLOTS);
      end else begin
         scan_start = req_index[LIVE_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      next_fresh_in = next_fresh_ff;
      live_in       = live_ff;
      rsp_in        = rsp_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cnt_rd_en     = 1'b0;
      cnt_rd_addr   = idx_ff;
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = idx_ff;
      cnt_wr_data   = alu.sum;
      fq_rd_en      = 1'b0;
      fq_wr_en      = 1'b0;
      finish        = 1'b0;
      res           = '{slot: '0, status: STAT_OK, flag: 1'b0, vacuum: 1'b0, live: '0};

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
            cnt_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = rsa_mode_type'(req_mode);
               case (rsa_mode_type'(req_mode))
                  MODE_CREATE: begin
                     if (free_count_ff != '0) begin
                        fq_rd_en = 1'b1;
                        state_in = ST_FQ;
                     end else if (next_fresh_ff == LIVE_W'(SLOTS)) begin
                        finish     = 1'b1;
                        res.status = STAT_FULL;
                     end else begin
                        idx_in        = next_fresh_ff[SLOT_W-1:0];
                        next_fresh_in = next_fresh_ff + 1'b1;
                        cnt_rd_en     = 1'b1;
                        cnt_rd_addr   = next_fresh_ff[SLOT_W-1:0];
                        state_in      = ST_RMW;
                     end
                  end
                  MODE_GRAB, MODE_DROP, MODE_QUERY: begin
                     if (!in_range) begin
                        finish     = 1'b1;
                        res.status = STAT_RANGE;
                     end else begin
                        idx_in      = req_index[SLOT_W-1:0];
                        cnt_rd_en   = 1'b1;
                        cnt_rd_addr = req_index[SLOT_W-1:0];
                        state_in    = ST_RMW;
                     end
                  end
                  MODE_SCAN_BELOW, MODE_SCAN_TOP: begin
                     if (scan_start == '0) begin
                        finish     = 1'b1;
                        res.status = STAT_NONE;
                     end else begin
                        idx_in      = SLOT_W'(scan_start - 1'b1);
                        cnt_rd_en   = 1'b1;
                        cnt_rd_addr = SLOT_W'(scan_start - 1'b1);
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_FQ: begin
            idx_in        = fq_rd_data;
            free_count_in = free_count_ff - 1'b1;
            free_head_in  = free_head_ff + 1'b1;
            cnt_rd_en     = 1'b1;
            cnt_rd_addr   = fq_rd_data;
            state_in      = ST_RMW;
         end
         ST_RMW: begin
            finish = 1'b1;
            case (mode_ff)
               MODE_CREATE: begin
                  if (!alu.is_zero) begin
                     res.status = STAT_CORRUPT;
                  end else begin
                     cnt_wr_en   = 1'b1;
                     cnt_wr_data = COUNT_BITS'(1);
                     live_in     = live_ff + 1'b1;
                     res.slot    = idx_ff;
                  end
               end
               MODE_GRAB: begin
                  if (alu.is_zero) begin
                     res.status = STAT_NO_ENTRY;
                  end else if (alu.is_max) begin
                     res.status = STAT_OVERFLOW;
                  end else begin
                     cnt_wr_en = 1'b1;
                  end
               end
               MODE_DROP: begin
                  if (alu.is_zero) begin
                     res.status = STAT_NO_ENTRY;
                  end else begin
                     cnt_wr_en = 1'b1;
                     if (alu.sum_zero) begin
                        res.flag = 1'b1;
                        live_in  = live_ff - 1'b1;
                        if (free_count_ff != FQ_CNT_W'(FREE_DEPTH)) begin
                           fq_wr_en      = 1'b1;
                           free_count_in = free_count_ff + 1'b1;
                        end
                     end
                  end
               end
               MODE_QUERY: begin
                  res.flag = !alu.is_zero;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (!alu.is_zero) begin
               finish   = 1'b1;
               res.slot = idx_ff;
            end else if (idx_ff == '0) begin
               finish     = 1'b1;
               res.status = STAT_NONE;
            end else begin
               idx_in      = idx_ff - 1'b1;
               cnt_rd_en   = 1'b1;
               cnt_rd_addr = idx_ff - 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         res.vacuum = free_count_in >= FQ_CNT_W'(VACUUM_LEVEL);
         res.live   = live_in;
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            hold_in  = res;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         free_head_ff  <= '0;
         free_count_ff <= '0;
         next_fresh_ff <= '0;
         live_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         next_fresh_ff <= next_fresh_in;
         live_ff       <= live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot           = rsp_ff.slot;
   assign rsp_status         = rsp_ff.status;
   assign rsp_flag           = rsp_ff.flag;
   assign rsp_vacuum_request = rsp_ff.vacuum;
   assign rsp_live_count     = rsp_ff.live;

   // live plus queued slots never exceed the slots ever handed out
   `RSA_ASSERT_IMP(a_slot_budget, clock, reset, 1'b1,
      SUM_W'(live_ff) + SUM_W'(free_count_ff) <= SUM_W'(next_fresh_ff))
   `RSA_ASSERT_IMP(a_free_bound, clock, reset, 1'b1,
      free_count_ff <= FQ_CNT_W'(FREE_DEPTH))
   `RSA_ASSERT_IMP(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff)
   `RSA_ASSERT_NXT(a_hold_drains, clock, reset, state_ff == ST_HOLD && out_free,
      rsp_valid_ff && state_ff == ST_IDLE)

endmodule
`default_nettype wire
